FILE: hw/rtl/tridiagonal_sturm_sign_count_top_assert.svh
// assertion macros for the sturm sign count block
// used by tridiagonal_sturm_sign_count_top, no other dependencies
`ifndef TRIDIAGONAL_STURM_SIGN_COUNT_TOP_ASSERT_SVH
`define TRIDIAGONAL_STURM_SIGN_COUNT_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STSC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define STSC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/stsc_pkg.sv
// shared types and constants for the sturm sign count block
// no dependencies; used by stsc_div, tridiagonal_sturm_sign_count_top and tb_top
package stsc_pkg;

   localparam int COUNT_W = 11;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // one matrix row
   typedef struct packed {
      logic signed [31:0] diag_value;
      logic signed [31:0] sub_value;
      logic signed [31:0] super_value;
      logic               last_row;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [COUNT_W-1:0] sign_changes;
      logic               zero_pivot;
   } rsp_type;

   // divider request: start pulse with operands
   typedef struct packed {
      logic               start;
      logic signed [31:0] num;
      logic signed [31:0] den;
   } div_req_type;

   // divider response: done pulse with saturated quotient
   typedef struct packed {
      logic               done;
      logic signed [31:0] quot;
   } div_rsp_type;

endpackage

FILE: hw/rtl/stsc_div.sv
// iterative q16.16 divider, (num * 2^16) / den truncated toward zero, saturated
// depends on stsc_pkg for the request and response structs
module stsc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  stsc_pkg::div_req_type div_req,
   output stsc_pkg::div_rsp_type div_rsp
);

   localparam int DIVIDEND_W = 48;
   localparam int STEP_BITS  = 2;
   localparam int STEPS      = DIVIDEND_W / STEP_BITS;
   localparam int CNT_W      = $clog2(STEPS);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_RUN  = 2'd1;
   localparam logic [1:0] D_FIX  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [31:0]           dmag_ff, dmag_in;
   logic signed [31:0]    quot_ff, quot_in;

   logic [31:0]           num_mag;
   logic [31:0]           den_mag;
   logic [31:0]           step_rem;
   logic [DIVIDEND_W-1:0] step_quo;
   logic [32:0]           trial;

   // operand magnitudes, most negative value maps to 2^31
   assign num_mag = div_req.num[31] ? (~div_req.num + 32'd1) : div_req.num;
   assign den_mag = div_req.den[31] ? (~div_req.den + 32'd1) : div_req.den;

   // restoring division, two quotient bits a cycle
   always_comb begin
      step_rem = rem_ff;
      step_quo = quo_ff;
      trial    = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial = {step_rem, step_quo[DIVIDEND_W-1]};
         if (trial >= {1'b0, dmag_ff}) begin
            step_rem = 32'(trial - {1'b0, dmag_ff});
            step_quo = {step_quo[DIVIDEND_W-2:0], 1'b1};
         end else begin
            step_rem = trial[31:0];
            step_quo = {step_quo[DIVIDEND_W-2:0], 1'b0};
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dmag_in  = dmag_ff;
      quot_in  = quot_ff;
      unique case (state_ff)
         D_IDLE: begin
            if (div_req.start) begin
               neg_in = div_req.num[31] ^ div_req.den[31];
               if (div_req.den == '0) begin
                  // zero divisor: saturate by the sign of the numerator
                  done_in = 1'b1;
                  if (div_req.num[31]) begin
                     quot_in = stsc_pkg::Q_MIN;
                  end else if (div_req.num != '0) begin
                     quot_in = stsc_pkg::Q_MAX;
                  end else begin
                     quot_in = '0;
                  end
               end else begin
                  rem_in   = '0;
                  quo_in   = {num_mag, 16'd0};
                  dmag_in  = den_mag;
                  cnt_in   = '0;
                  state_in = D_RUN;
               end
            end
         end
         D_RUN: begin
            rem_in = step_rem;
            quo_in = step_quo;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = D_FIX;
            end
         end
         D_FIX: begin
            // apply sign and saturate
            if (neg_ff) begin
               if (quo_ff > 48'h0000_8000_0000) begin
                  quot_in = stsc_pkg::Q_MIN;
               end else begin
                  quot_in = ~quo_ff[31:0] + 32'd1;
               end
            end else begin
               if (quo_ff > 48'h0000_7FFF_FFFF) begin
                  quot_in = stsc_pkg::Q_MAX;
               end else begin
                  quot_in = quo_ff[31:0];
               end
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

FILE: hw/rtl/tridiagonal_sturm_sign_count_top.sv
// Sturm sequence sign counter for a symmetric tridiagonal matrix, Q16.16.
// Depends on stsc_pkg, stsc_div and tridiagonal_sturm_sign_count_top_assert.svh.
//
// Usage:
//  - csr_wr_en / csr_wr_data load the shift lambda; write only while idle.
//  - req_* takes one matrix row per beat (valid/ready); last_row ends a matrix.
//  - rsp_* gives one beat per matrix: sign change count and zero pivot flag.
// Row flow:
//  - a row that is not last registers the shifted diagonal, the 32x32
//    product and the pivot in turn, then the radix-4 divider (24 steps
//    and a fix-up) forms super / pivot; req_ready is low for all of that
//  - the last row skips the divider: product, pivot, update, then emit
// Stalls: the result sits in an output register; the block keeps taking rows
//  of the next matrix, and only holds at its final row while the previous
//  result beat is still waiting.
// Reset: synchronous, active high; lambda returns to 0, the carried recurrence state
//  and the output valid flag are cleared; the output data register is not.
module tridiagonal_sturm_sign_count_top #(
   parameter int MAX_ORDER = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic signed [31:0] csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  stsc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output stsc_pkg::rsp_type rsp_data
);

`include "tridiagonal_sturm_sign_count_top_assert.svh"

   localparam int CW = stsc_pkg::COUNT_W;
   localparam logic [CW-1:0] COUNT_CAP = CW'((MAX_ORDER < 2047) ? MAX_ORDER : 2047);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_PIV  = 3'd2;
   localparam logic [2:0] S_UPD  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic signed [31:0]  shift_ff, shift_in;
   stsc_pkg::req_type   row_ff, row_in;
   logic signed [31:0]  shifted_ff, shifted_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic signed [31:0]  pivot_ff, pivot_in;
   logic signed [31:0]  prev_ff, prev_in;
   logic signed [31:0]  ratio_ff, ratio_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                mid_ff, mid_in;
   logic                zero_ff, zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   stsc_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   stsc_pkg::div_req_type div_req;
   stsc_pkg::div_rsp_type div_rsp;

   logic               req_fire;
   logic [32:0]        shift_diff;
   logic [32:0]        piv_diff;
   logic signed [31:0] prod_q;
   logic               bump;
   logic               out_free;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // diag - lambda, saturated
   assign shift_diff = {req_data.diag_value[31], req_data.diag_value}
                     - {shift_ff[31], shift_ff};

   // product floor-shifted by 16, saturated to 32 bits
   always_comb begin
      if (prod_ff[63:47] == '0 || prod_ff[63:47] == '1) begin
         prod_q = prod_ff[47:16];
      end else if (prod_ff[63]) begin
         prod_q = stsc_pkg::Q_MIN;
      end else begin
         prod_q = stsc_pkg::Q_MAX;
      end
   end

   // pivot difference; on a first row the ratio is zero so the product is too
   assign piv_diff = {shifted_ff[31], shifted_ff} - {prod_q[31], prod_q};

   // sign change against previous pivot, or against +1 on a first row
   always_comb begin
      if (!mid_ff) begin
         bump = pivot_ff[31];
      end else begin
         bump = (prev_ff[31] && !pivot_ff[31] && pivot_ff != '0)
             || (pivot_ff[31] && !prev_ff[31] && prev_ff != '0);
      end
   end

   // divider request
   assign div_req.start = (state_ff == S_UPD) && !row_ff.last_row;
   assign div_req.num   = row_ff.super_value;
   assign div_req.den   = pivot_ff;

   stsc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // row sequencer
   always_comb begin
      state_in     = state_ff;
      shift_in     = csr_wr_en ? csr_wr_data : shift_ff;
      row_in       = row_ff;
      shifted_in   = shifted_ff;
      prod_in      = prod_ff;
      pivot_in     = pivot_ff;
      prev_in      = prev_ff;
      ratio_in     = ratio_ff;
      count_in     = count_ff;
      mid_in       = mid_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               row_in = req_data;
               if (shift_diff[32] != shift_diff[31]) begin
                  shifted_in = shift_diff[32] ? stsc_pkg::Q_MIN : stsc_pkg::Q_MAX;
               end else begin
                  shifted_in = shift_diff[31:0];
               end
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = row_ff.sub_value * ratio_ff;
            state_in = S_PIV;
         end
         S_PIV: begin
            if (piv_diff[32] != piv_diff[31]) begin
               pivot_in = piv_diff[32] ? stsc_pkg::Q_MIN : stsc_pkg::Q_MAX;
            end else begin
               pivot_in = piv_diff[31:0];
            end
            state_in = S_UPD;
         end
         S_UPD: begin
            if (bump && count_ff < COUNT_CAP) begin
               count_in = count_ff + CW'(1);
            end
            if (pivot_ff == '0) begin
               zero_in = 1'b1;
            end
            if (row_ff.last_row) begin
               state_in = S_EMIT;
            end else begin
               prev_in  = pivot_ff;
               mid_in   = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               ratio_in = div_rsp.quot;
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            // hand the result over and start a fresh matrix
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.sign_changes = count_ff;
               rsp_data_in.zero_pivot   = zero_ff;
               prev_in                  = '0;
               ratio_in                 = '0;
               count_in                 = '0;
               mid_in                   = 1'b0;
               zero_in                  = 1'b0;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         shift_ff     <= '0;
         prev_ff      <= '0;
         ratio_ff     <= '0;
         count_ff     <= '0;
         mid_ff       <= 1'b0;
         zero_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         shift_ff     <= shift_in;
         prev_ff      <= prev_in;
         ratio_ff     <= ratio_in;
         count_ff     <= count_in;
         mid_ff       <= mid_in;
         zero_ff      <= zero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      shifted_ff  <= shifted_in;
      prod_ff     <= prod_in;
      pivot_ff    <= pivot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `STSC_ASSERT_NOW(a_count_capped, rsp_valid, rsp_data.sign_changes <= COUNT_CAP,
      "sign count above cap")
   `STSC_ASSERT_NEXT(a_busy_after_row, req_fire, !req_ready,
      "row accepted while previous still in progress")
   `STSC_ASSERT_NOW(a_fresh_matrix, !mid_ff && state_ff == S_IDLE,
      count_ff == '0 && ratio_ff == '0 && !zero_ff, "state not cleared between matrices")
   `STSC_ASSERT_NEXT(a_div_only_mid_row, div_req.start, state_ff == S_DIV && mid_ff,
      "divider started outside a continuing row")

endmodule

FILE: tb/tb_top.sv
// self-checking bench for the tridiagonal sturm sign counter: matrix rows in, counts out
// needs stsc_pkg and tridiagonal_sturm_sign_count_top; the expected counts come
// from a pivot recurrence model held in a small scoreboard class
`timescale 1ns / 100ps

module tb_top;

   localparam int MAX_ORDER     = 1024;
   localparam int COUNT_CAP     = (MAX_ORDER < 2047) ? MAX_ORDER : 2047;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 500;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_ROWS  = 24;
   localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

   // pivot recurrence model and the queue of counts still owed by the block
   class sturm_count_book;
      logic signed [31:0] shift;
      logic signed [31:0] last_pivot;
      logic signed [31:0] last_ratio;
      logic [stsc_pkg::COUNT_W-1:0] changes;
      logic               in_matrix;
      logic               saw_zero;
      stsc_pkg::rsp_type  counts_due[$];
      int                 faults;

      function new();
         shift  = '0;
         faults = 0;
         restart();
      endfunction

      function void restart();
         last_pivot = '0;
         last_ratio = '0;
         changes    = '0;
         in_matrix  = 1'b0;
         saw_zero   = 1'b0;
      endfunction

      function logic signed [31:0] clamp(input longint v);
         if (v > longint'(stsc_pkg::Q_MAX)) return stsc_pkg::Q_MAX;
         if (v < longint'(stsc_pkg::Q_MIN)) return stsc_pkg::Q_MIN;
         return v[31:0];
      endfunction

      // super / pivot in Q16.16, truncated toward zero, saturating on overflow and on a zero pivot
      function logic signed [31:0] quotient(input logic signed [31:0] num,
                                            input logic signed [31:0] den);
         if (den == 0) begin
            if (num > 0) return stsc_pkg::Q_MAX;
            if (num < 0) return stsc_pkg::Q_MIN;
            return '0;
         end
         return clamp((longint'(num) * 65536) / longint'(den));
      endfunction

      function void count_up();
         if (changes < COUNT_CAP) changes++;
      endfunction

      function int pending();
         return counts_due.size();
      endfunction

      // accepted row beat: advance the recurrence, queue a count on the last row
      function void note_row(input stsc_pkg::req_type row);
         logic signed [31:0] diag, sub, sup, shifted, prod, pivot;
         stsc_pkg::rsp_type  res;
         diag    = $signed(row.diag_value);
         sub     = $signed(row.sub_value);
         sup     = $signed(row.super_value);
         shifted = clamp(longint'(diag) - longint'(shift));
         if (!in_matrix) begin
            pivot = shifted;
            if (pivot < 0) count_up();
         end else begin
            prod  = clamp((longint'(sub) * longint'(last_ratio)) >>> 16);
            pivot = clamp(longint'(shifted) - longint'(prod));
            if ((last_pivot < 0 && pivot > 0) || (last_pivot > 0 && pivot < 0))
               count_up();
         end
         if (pivot == 0) saw_zero = 1'b1;
         if (row.last_row) begin
            res.sign_changes = changes;
            res.zero_pivot   = saw_zero;
            counts_due.push_back(res);
            restart();
         end else begin
            last_ratio = quotient(sup, pivot);
            last_pivot = pivot;
            in_matrix  = 1'b1;
         end
      endfunction

      // accepted result beat against the oldest expected count
      function void check_result(input stsc_pkg::rsp_type got);
         stsc_pkg::rsp_type want;
         if (counts_due.size() == 0) begin
            $error("unexpected result beat: sign_changes %0d zero_pivot %0d",
                   got.sign_changes, got.zero_pivot);
            faults++;
            return;
         end
         want = counts_due.pop_front();
         if (got.sign_changes !== want.sign_changes) begin
            $error("sign_changes: expected %0d, actual %0d",
                   want.sign_changes, got.sign_changes);
            faults++;
         end
         if (got.zero_pivot !== want.zero_pivot) begin
            $error("zero_pivot: expected %0d, actual %0d",
                   want.zero_pivot, got.zero_pivot);
            faults++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic signed [31:0] csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   stsc_pkg::req_type  req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   stsc_pkg::rsp_type  rsp_data;

   sturm_count_book    book;
   int                 send_gap_pct = 0;
   int                 recv_gap_pct = 0;
   int                 holds_asked = 0;
   int                 holds_taken = 0;
   int                 hold_left = 0;
   int                 cycle_count = 0;

   tridiagonal_sturm_sign_count_top #(
      .MAX_ORDER(MAX_ORDER)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: check accepted beats, random stalls and long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) book.check_result(rsp_data);
         if (holds_taken != holds_asked) begin
            holds_taken++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_gap_pct);
         end
      end
   end

   function automatic stsc_pkg::req_type make_row(input logic signed [31:0] d,
                                                  input logic signed [31:0] s,
                                                  input logic signed [31:0] u,
                                                  input logic last);
      stsc_pkg::req_type r;
      r.diag_value  = d;
      r.sub_value   = s;
      r.super_value = u;
      r.last_row    = last;
      return r;
   endfunction

   // modest values most often, with extremes, zero, full-range and whole numbers mixed in
   function automatic logic signed [31:0] any_q();
      logic signed [31:0] v;
      case ($urandom_range(9))
         0: v = stsc_pkg::Q_MAX;
         1: v = stsc_pkg::Q_MIN;
         2: v = '0;
         3, 4: v = $urandom();
         5: v = ($urandom_range(8) << 16) - 32'h0004_0000;
         default: v = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      endcase
      return v;
   endfunction

   // diagonal equal to the shift now and then, so zero pivots turn up
   function automatic logic signed [31:0] pick_diag();
      if ($urandom_range(6) == 0) return book.shift;
      return any_q();
   endfunction

   task automatic write_shift(input logic signed [31:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      book.shift = v;
   endtask

   // one row beat; valid stays up across back-to-back beats
   task automatic send_row(input stsc_pkg::req_type row);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= row;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      book.note_row(row);
   endtask

   task automatic send_matrix(input int rows);
      for (int i = 0; i < rows; i++)
         send_row(make_row(pick_diag(), any_q(), any_q(), i == rows - 1));
   endtask

   task automatic random_rows(input int budget);
      int sent;
      int rows;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(19))
            0: rows = $urandom_range(31, 80);
            1, 2, 3, 4, 5: rows = $urandom_range(7, 30);
            default: rows = $urandom_range(1, 6);
         endcase
         send_matrix(rows);
         sent += rows;
      end
   endtask

   // sender stops until every count is back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic signed [31:0] shift_plan [SEGMENTS];
      book = new();
      shift_plan = '{ONE_Q, stsc_pkg::Q_MAX, 32'sh0, stsc_pkg::Q_MIN, -32'sh0002_8000,
                     32'sh0, 32'sh0, 32'sh0};
      shift_plan[2] = $urandom();
      shift_plan[5] = $urandom_range(32'h0010_0000) - 32'h0008_0000;
      shift_plan[7] = $urandom_range(32'h0004_0000) - 32'h0002_0000;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at the reset shift of zero
      // single-row matrices: positive, negative and zero pivot
      send_row(make_row(ONE_Q, stsc_pkg::Q_MIN, stsc_pkg::Q_MAX, 1'b1));
      send_row(make_row(-ONE_Q, stsc_pkg::Q_MAX, stsc_pkg::Q_MIN, 1'b1));
      send_row(make_row('0, '0, '0, 1'b1));
      // saturating extremes of every field
      send_row(make_row(stsc_pkg::Q_MAX, stsc_pkg::Q_MIN, stsc_pkg::Q_MAX, 1'b0));
      send_row(make_row(stsc_pkg::Q_MIN, stsc_pkg::Q_MAX, stsc_pkg::Q_MAX, 1'b1));
      send_row(make_row(stsc_pkg::Q_MIN, stsc_pkg::Q_MIN, stsc_pkg::Q_MIN, 1'b0));
      send_row(make_row(stsc_pkg::Q_MIN, stsc_pkg::Q_MIN, stsc_pkg::Q_MIN, 1'b1));
      // zero pivots with positive, negative and zero super entries
      send_row(make_row('0, stsc_pkg::Q_MIN, ONE_Q, 1'b0));
      send_row(make_row(ONE_Q, ONE_Q, -ONE_Q, 1'b0));
      send_row(make_row('0, '0, -ONE_Q, 1'b0));
      send_row(make_row(2 * ONE_Q, 3 * ONE_Q, '0, 1'b1));
      send_row(make_row('0, stsc_pkg::Q_MAX, '0, 1'b0));
      send_row(make_row(-ONE_Q, stsc_pkg::Q_MIN, stsc_pkg::Q_MAX, 1'b1));
      // ordinary sign changes
      send_row(make_row(2 * ONE_Q, '0, ONE_Q, 1'b0));
      send_row(make_row(ONE_Q, 4 * ONE_Q, -ONE_Q, 1'b0));
      send_row(make_row(-3 * ONE_Q, -ONE_Q, 32'sh0000_8000, 1'b1));
      settle();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 3) begin
            send_gap_pct = 16;
            recv_gap_pct = 45;
         end else if (seg < 6) begin
            send_gap_pct = 45;
            recv_gap_pct = 16;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         write_shift(shift_plan[seg]);

         // long receiver hold-off so the output register fills and rows back up
         if (seg == 0) begin
            holds_asked++;
            for (int m = 0; m < 5; m++) send_matrix($urandom_range(1, 3));
            settle();
         end

         // count saturation: strictly alternating pivots for more rows than the cap
         if (seg == 6) begin
            for (int i = 0; i < COUNT_CAP + 6; i++)
               send_row(make_row((i % 2 == 0) ? -ONE_Q : ONE_Q, '0, any_q(),
                                 i == COUNT_CAP + 5));
         end

         random_rows(SEGMENT_ROWS);
         settle();
      end

      if (book.pending() == 0 && book.faults == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
